[rtl/huffman_code_bit_packer_macros.svh]
// Assertion macros for the Huffman code bit packer.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`ifndef SYNTHESIS
`define HCBP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hcbp assertion failed");
`define HCBP_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hcbp reset assertion failed");
`else
`define HCBP_ASSERT(lbl, prop)
`define HCBP_ASSERT_RST(lbl, prop)
`endif
`endif

[rtl/hcbp_pkg.sv]
// Package with the types and constants of the Huffman code bit packer.
`default_nettype none
package hcbp_pkg;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int SYM_W     = 8;
    localparam int MAX_BYTES = 4;
    localparam int WIN_W     = CODE_W + BYTE_W - 1;
    localparam int ALIGN_W   = MAX_BYTES * BYTE_W;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } entry_t;
endpackage
`default_nettype wire

[rtl/huffman_code_bit_packer.sv]
// Huffman code bit packer: code table, MSB-first bit packer and output byte buffer.
// A load transaction writes one code into the table, an encode transaction looks up its
// symbol and packs the code bits, first bit first, and a flush transaction pads the
// partial byte with zeros and sends it. The table is a RAM with a registered read, so
// packing works in the registered stage behind the input; table entries carry a valid bit
// that reset clears, so no clearing pass is needed. The packer takes a new transaction
// every cycle unless in_stall is high; the output buffer sends one byte per cycle while
// out_stall is low, so a following item that also yields bytes (up to four per item)
// holds the input stalled until the buffer's last byte is being taken before it can pack.
`default_nettype none
`include "huffman_code_bit_packer_macros.svh"
module huffman_code_bit_packer #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_CODE_LEN  = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  symbol,
    input  wire logic [31:0] code_bits,
    input  wire logic [5:0]  code_len,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [7:0]  out_byte,
    output logic             last
);
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CAP_LEN = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                                : hcbp_pkg::CODE_W;
    localparam int CNT_W   = $clog2(hcbp_pkg::MAX_BYTES + 1);

    logic                            in_take;
    logic                            in_range;
    logic [hcbp_pkg::LEN_W-1:0]      len_cap;
    logic [hcbp_pkg::CODE_W-1:0]     code_mask;
    hcbp_pkg::entry_t                wr_entry;
    hcbp_pkg::entry_t                rd_entry;
    logic                            tbl_we;
    logic [IDX_W-1:0]                tbl_addr;

    logic [TABLE_ENTRIES-1:0]        tvld_reg, tvld_next;
    logic                            s1_valid_reg, s1_valid_next;
    logic                            s1_flush_reg, s1_flush_next;
    logic                            s1_hit_reg, s1_hit_next;
    logic [hcbp_pkg::BYTE_W-1:0]     acc_reg, acc_next;
    logic [2:0]                      pend_reg, pend_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [hcbp_pkg::BYTE_W-1:0]     obuf_reg [hcbp_pkg::MAX_BYTES];
    logic [hcbp_pkg::BYTE_W-1:0]     obuf_next [hcbp_pkg::MAX_BYTES];

    logic [hcbp_pkg::CODE_W-1:0]     s1_code;
    logic [hcbp_pkg::LEN_W-1:0]      s1_len;
    logic [hcbp_pkg::WIN_W-1:0]      win;
    logic [hcbp_pkg::LEN_W-1:0]      total;
    logic [2:0]                      nbytes;
    logic [2:0]                      rem;
    logic [hcbp_pkg::WIN_W:0]        shifted;
    logic [hcbp_pkg::ALIGN_W-1:0]    aligned;
    logic                            out_take;
    logic                            obuf_free;
    logic                            s1_commit;
    logic                            s1_emit;

    assign in_take  = in_valid && !in_stall;
    assign in_range = ({1'b0, symbol} < 9'(TABLE_ENTRIES));
    assign tbl_addr = symbol[IDX_W-1:0];

    assign len_cap   = (code_len > hcbp_pkg::LEN_W'(CAP_LEN)) ? hcbp_pkg::LEN_W'(CAP_LEN)
                                                               : code_len;
    assign code_mask = (len_cap >= hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W)) ? '1
                     : ~({hcbp_pkg::CODE_W{1'b1}} << len_cap);
    assign wr_entry.code = code_bits & code_mask;
    assign wr_entry.len  = len_cap;
    assign tbl_we        = in_take && (op == hcbp_pkg::OP_LOAD) && in_range;

    hcbp_ram #(
        .WIDTH ($bits(hcbp_pkg::entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_addr),
        .wdata (wr_entry),
        .re    (in_take),
        .raddr (tbl_addr),
        .rdata (rd_entry)
    );

    // Packing of the staged transaction against the current accumulator.
    always_comb
    begin
        if (s1_flush_reg)
        begin
            s1_code = '0;
            s1_len  = (pend_reg == 3'd0) ? '0
                    : hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_W) - {3'b000, pend_reg};
        end
        else if (s1_hit_reg)
        begin
            s1_code = rd_entry.code;
            s1_len  = rd_entry.len;
        end
        else
        begin
            s1_code = '0;
            s1_len  = '0;
        end
        win     = ({{(hcbp_pkg::WIN_W - 7){1'b0}}, acc_reg[6:0]} << s1_len)
                | {7'b0000000, s1_code};
        total   = {3'b000, pend_reg} + s1_len;
        nbytes  = total[5:3];
        rem     = total[2:0];
        shifted = {win, 1'b0} << (hcbp_pkg::LEN_W'(hcbp_pkg::WIN_W) - total);
        aligned = shifted[hcbp_pkg::WIN_W -: hcbp_pkg::ALIGN_W];
    end

    assign out_take  = out_valid && !out_stall;
    assign obuf_free = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_take);
    assign s1_emit   = s1_valid_reg && (nbytes != 3'd0);
    assign s1_commit = s1_valid_reg && ((nbytes == 3'd0) || obuf_free);
    assign in_stall  = s1_valid_reg && !s1_commit;

    always_comb
    begin
        tvld_next = tvld_reg;
        if (tbl_we)
        begin
            tvld_next[tbl_addr] = 1'b1;
        end

        s1_valid_next = s1_valid_reg && !s1_commit;
        s1_flush_next = s1_flush_reg;
        s1_hit_next   = s1_hit_reg;
        if (in_take)
        begin
            s1_valid_next = (op == hcbp_pkg::OP_ENCODE) || (op == hcbp_pkg::OP_FLUSH);
            s1_flush_next = (op == hcbp_pkg::OP_FLUSH);
            s1_hit_next   = in_range && tvld_reg[tbl_addr];
        end

        acc_next  = acc_reg;
        pend_next = pend_reg;
        if (s1_commit)
        begin
            acc_next  = {1'b0, win[6:0]} & ~({hcbp_pkg::BYTE_W{1'b1}} << rem);
            pend_next = rem;
        end

        cnt_next = cnt_reg;
        for (int i = 0; i < hcbp_pkg::MAX_BYTES; i++)
        begin
            obuf_next[i] = obuf_reg[i];
        end
        if (s1_commit && s1_emit)
        begin
            cnt_next = CNT_W'(nbytes);
            for (int i = 0; i < hcbp_pkg::MAX_BYTES; i++)
            begin
                obuf_next[i] = aligned[hcbp_pkg::ALIGN_W - 1 - hcbp_pkg::BYTE_W * i
                                       -: hcbp_pkg::BYTE_W];
            end
        end
        else if (out_take)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < hcbp_pkg::MAX_BYTES - 1; i++)
            begin
                obuf_next[i] = obuf_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvld_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_flush_reg <= 1'b0;
            s1_hit_reg   <= 1'b0;
            acc_reg      <= '0;
            pend_reg     <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            tvld_reg     <= tvld_next;
            s1_valid_reg <= s1_valid_next;
            s1_flush_reg <= s1_flush_next;
            s1_hit_reg   <= s1_hit_next;
            acc_reg      <= acc_next;
            pend_reg     <= pend_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < hcbp_pkg::MAX_BYTES; i++)
        begin
            obuf_reg[i] <= obuf_next[i];
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_byte  = obuf_reg[0];
    assign last      = (cnt_reg == CNT_W'(1));

    `HCBP_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(hcbp_pkg::MAX_BYTES))
    `HCBP_ASSERT(a_busy_holds_input, (s1_emit && !obuf_free) |-> in_stall)
    `HCBP_ASSERT(a_flush_clears, (s1_commit && s1_flush_reg) |=> (pend_reg == 3'd0))
    `HCBP_ASSERT_RST(a_reset_idle, !rst_n |-> (cnt_reg == '0 && !s1_valid_reg))
endmodule
`default_nettype wire

[rtl/hcbp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module hcbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire
